// ----- src/lgb_pkg.sv -----
`timescale 1ns / 1ps
// lgb_pkg: shared types and constants of the line graph builder
// payload structs, store sizes and the controller/datapath command and status structs
package lgb_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 64;

    localparam int VTX_W     = 6;
    localparam int NUM_W     = 7;
    localparam int EIDX_W    = $clog2(MAX_EDGES);
    localparam int ROW_W     = MAX_EDGES;
    localparam int ELIST_W   = 2 * VTX_W;
    localparam int TBL_DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int TBL_AW    = 2 * VTX_W;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_BUILD = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [VTX_W-1:0] end_a;
        logic [VTX_W-1:0] end_b;
    } t_in_item;

    typedef struct packed {
        logic [NUM_W-1:0] row_edge;
        logic [ROW_W-1:0] row_bits;
        logic             last_row;
        logic             load_error;
    } t_out_item;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic drop;
        logic edge_rd;
        logic edge_lat;
        logic cell_rd;
        logic cell_chk;
        logic cell_val;
        logic mark_rd;
        logic mark_wr;
        logic mark_v;
        logic i_next;
        logic edge_wb;
        logic k_first;
        logic k_next;
        logic out_rd;
        logic out_load;
        logic empty_load;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic req_build;
        logic drop;
        logic cnt_zero;
        logic n_zero;
        logic k_last;
        logic i_last;
        logic found_u;
        logic found_v;
        logic fv_pend;
        logic out_free;
    } t_sts;

endpackage

// ----- src/line_graph_builder.sv -----
`timescale 1ns / 1ps
// line_graph_builder: loads an edge list and emits its line graph, one row per edge
// a load writes the edge list and both table cells (a dropped one flags an error); a build
// fills the adjacency rows by read-modify-write, edge by edge, then emits one row per edge;
// one item is handled at a time
// synchronous active-low reset clears control state and all valid bits; the vertex table
// is checked against the edge list on read, so no clearing pass is needed
module line_graph_builder import lgb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [NUM_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    lgb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lgb_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign o_in_stall  = ~w_in_ready;
    assign o_cfg_ready = 1'b1;

endmodule

// ----- src/lgb_ctrl.sv -----
`timescale 1ns / 1ps
// lgb_ctrl: sequencer of the line graph builder
// depends on lgb_pkg; drives the datapath through t_cmd and reads t_sts
module lgb_ctrl import lgb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_LOAD2     = 4'd1;
    localparam logic [3:0] S_EDGE_RD   = 4'd2;
    localparam logic [3:0] S_EDGE_LAT  = 4'd3;
    localparam logic [3:0] S_CELL_RD   = 4'd4;
    localparam logic [3:0] S_CELL_CHK  = 4'd5;
    localparam logic [3:0] S_CELL_VAL  = 4'd6;
    localparam logic [3:0] S_MARK_U_RD = 4'd7;
    localparam logic [3:0] S_MARK_U_WR = 4'd8;
    localparam logic [3:0] S_MARK_V_RD = 4'd9;
    localparam logic [3:0] S_MARK_V_WR = 4'd10;
    localparam logic [3:0] S_EDGE_WB   = 4'd11;
    localparam logic [3:0] S_OUT_RD    = 4'd12;
    localparam logic [3:0] S_OUT_LOAD  = 4'd13;
    localparam logic [3:0] S_EMPTY     = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [3:0] w_after_vtx;

    // where to go once the current vertex is done
    always_comb begin
        if (i_sts.i_last) begin
            w_after_vtx = S_EDGE_WB;
        end else begin
            w_after_vtx = S_CELL_RD;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_sts.req_build) begin
                        if (i_sts.cnt_zero) begin
                            n_state = S_EMPTY;
                        end else begin
                            o_cmd.k_first = 1'b1;
                            n_state       = S_EDGE_RD;
                        end
                    end else if (i_sts.drop) begin
                        o_cmd.drop = 1'b1;
                    end else begin
                        o_cmd.load_a = 1'b1;
                        n_state      = S_LOAD2;
                    end
                end
            end
            S_LOAD2: begin
                o_cmd.load_b = 1'b1;
                n_state      = S_IDLE;
            end
            S_EDGE_RD: begin
                o_cmd.edge_rd = 1'b1;
                n_state       = S_EDGE_LAT;
            end
            S_EDGE_LAT: begin
                o_cmd.edge_lat = 1'b1;
                if (i_sts.n_zero) begin
                    n_state = S_EDGE_WB;
                end else begin
                    n_state = S_CELL_RD;
                end
            end
            S_CELL_RD: begin
                o_cmd.cell_rd = 1'b1;
                n_state       = S_CELL_CHK;
            end
            S_CELL_CHK: begin
                o_cmd.cell_chk = 1'b1;
                n_state        = S_CELL_VAL;
            end
            S_CELL_VAL: begin
                o_cmd.cell_val = 1'b1;
                if (i_sts.found_u) begin
                    n_state = S_MARK_U_RD;
                end else if (i_sts.found_v) begin
                    n_state = S_MARK_V_RD;
                end else begin
                    o_cmd.i_next = ~i_sts.i_last;
                    n_state      = w_after_vtx;
                end
            end
            S_MARK_U_RD: begin
                o_cmd.mark_rd = 1'b1;
                n_state       = S_MARK_U_WR;
            end
            S_MARK_U_WR: begin
                o_cmd.mark_wr = 1'b1;
                if (i_sts.fv_pend) begin
                    n_state = S_MARK_V_RD;
                end else begin
                    o_cmd.i_next = ~i_sts.i_last;
                    n_state      = w_after_vtx;
                end
            end
            S_MARK_V_RD: begin
                o_cmd.mark_rd = 1'b1;
                o_cmd.mark_v  = 1'b1;
                n_state       = S_MARK_V_WR;
            end
            S_MARK_V_WR: begin
                o_cmd.mark_wr = 1'b1;
                o_cmd.mark_v  = 1'b1;
                o_cmd.i_next  = ~i_sts.i_last;
                n_state       = w_after_vtx;
            end
            S_EDGE_WB: begin
                o_cmd.edge_wb = 1'b1;
                if (i_sts.k_last) begin
                    o_cmd.k_first = 1'b1;
                    n_state       = S_OUT_RD;
                end else begin
                    o_cmd.k_next = 1'b1;
                    n_state      = S_EDGE_RD;
                end
            end
            S_OUT_RD: begin
                o_cmd.out_rd = 1'b1;
                n_state      = S_OUT_LOAD;
            end
            S_OUT_LOAD: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.k_last) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.k_next = 1'b1;
                        n_state      = S_OUT_RD;
                    end
                end
            end
            S_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.empty_load = 1'b1;
                    o_cmd.finish     = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/lgb_dpath.sv -----
`timescale 1ns / 1ps
// lgb_dpath: stores, counters and output register of the line graph builder
// depends on lgb_pkg; holds the vertex table, edge list and adjacency memories
module lgb_dpath import lgb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_item         i_in_data,
    input  logic             i_cfg_valid,
    input  logic [NUM_W-1:0] i_cfg_data,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output t_out_item        o_out_data
);

    // control state
    logic [NUM_W-1:0]  r_num_vtx;
    logic [NUM_W-1:0]  r_cnt;
    logic              r_err;
    logic [NUM_W-1:0]  r_k;
    logic [VTX_W-1:0]  r_i;
    logic [ROW_W-1:0]  r_row_vld;
    logic              r_out_valid;

    // payload
    logic [VTX_W-1:0]  r_u;
    logic [VTX_W-1:0]  r_v;
    logic [ROW_W-1:0]  r_acc;
    logic              r_fv_pend;
    t_out_item         r_out;

    // memories and their registered read data
    logic [NUM_W-1:0]   r_tbl [TBL_DEPTH];
    logic [NUM_W-1:0]   r_tu_q;
    logic [NUM_W-1:0]   r_tv_q;
    logic [ELIST_W-1:0] r_elist [MAX_EDGES];
    logic [ELIST_W-1:0] r_ea_q;
    logic [ELIST_W-1:0] r_eb_q;
    logic [ROW_W-1:0]   r_adj [MAX_EDGES];
    logic [ROW_W-1:0]   r_adj_q;
    logic               r_adj_vld_q;

    logic [NUM_W-1:0]  w_n_eff;
    logic [NUM_W-1:0]  w_km1;
    logic [NUM_W-1:0]  w_tum1;
    logic [NUM_W-1:0]  w_tvm1;
    logic [NUM_W-1:0]  w_mark_m1;
    logic [NUM_W-1:0]  w_i_inc;
    logic [ROW_W-1:0]  w_adj_rd;
    logic [ROW_W-1:0]  w_k_bit;
    logic [EIDX_W-1:0] w_adj_raddr;
    logic [EIDX_W-1:0] w_adj_waddr;
    logic [ROW_W-1:0]  w_adj_wdata;
    logic [EIDX_W-1:0] w_ea_addr;
    logic              w_match_u;
    logic              w_match_v;
    logic              w_found_u;
    logic              w_found_v;
    logic              w_drop;
    logic              w_out_take;

    assign w_n_eff  = (r_num_vtx > NUM_W'(MAX_VERTICES)) ? NUM_W'(MAX_VERTICES) : r_num_vtx;
    assign w_km1    = r_k - NUM_W'(1);
    assign w_tum1   = r_tu_q - NUM_W'(1);
    assign w_tvm1   = r_tv_q - NUM_W'(1);
    assign w_mark_m1 = i_cmd.mark_v ? w_tvm1 : w_tum1;
    assign w_i_inc  = {1'b0, r_i} + NUM_W'(1);
    assign w_adj_rd = r_adj_vld_q ? r_adj_q : '0;
    assign w_k_bit  = ROW_W'(1) << w_km1[EIDX_W-1:0];

    assign w_drop = (r_cnt >= NUM_W'(MAX_EDGES))
                 || ({1'b0, i_in_data.end_a} >= w_n_eff)
                 || ({1'b0, i_in_data.end_b} >= w_n_eff);

    // a table cell counts only if it names a live edge that really joins those vertices
    assign w_match_u = ((r_ea_q[ELIST_W-1:VTX_W] == r_u) && (r_ea_q[VTX_W-1:0] == r_i))
                    || ((r_ea_q[ELIST_W-1:VTX_W] == r_i) && (r_ea_q[VTX_W-1:0] == r_u));
    assign w_match_v = ((r_eb_q[ELIST_W-1:VTX_W] == r_v) && (r_eb_q[VTX_W-1:0] == r_i))
                    || ((r_eb_q[ELIST_W-1:VTX_W] == r_i) && (r_eb_q[VTX_W-1:0] == r_v));
    assign w_found_u = (r_tu_q != '0) && (r_tu_q <= r_cnt) && w_match_u && (r_i != r_v);
    assign w_found_v = (r_tv_q != '0) && (r_tv_q <= r_cnt) && w_match_v && (r_i != r_u);

    assign w_out_take = r_out_valid && !i_out_stall;

    always_comb begin
        o_sts.req_build = (i_in_data.req_type == REQ_BUILD);
        o_sts.drop      = w_drop;
        o_sts.cnt_zero  = (r_cnt == '0);
        o_sts.n_zero    = (w_n_eff == '0);
        o_sts.k_last    = (r_k == r_cnt);
        o_sts.i_last    = (w_i_inc == w_n_eff);
        o_sts.found_u   = w_found_u;
        o_sts.found_v   = w_found_v;
        o_sts.fv_pend   = r_fv_pend;
        o_sts.out_free  = !r_out_valid || !i_out_stall;
    end

    always_comb begin
        if (i_cmd.mark_rd) begin
            w_adj_raddr = w_mark_m1[EIDX_W-1:0];
        end else begin
            w_adj_raddr = w_km1[EIDX_W-1:0];
        end
        if (i_cmd.mark_wr) begin
            w_adj_waddr = w_mark_m1[EIDX_W-1:0];
            w_adj_wdata = w_adj_rd | w_k_bit;
        end else begin
            w_adj_waddr = w_km1[EIDX_W-1:0];
            w_adj_wdata = r_acc;
        end
        if (i_cmd.edge_rd) begin
            w_ea_addr = w_km1[EIDX_W-1:0];
        end else begin
            w_ea_addr = w_tum1[EIDX_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vtx   <= NUM_W'(MAX_VERTICES);
            r_cnt       <= '0;
            r_err       <= 1'b0;
            r_k         <= '0;
            r_i         <= '0;
            r_row_vld   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_num_vtx <= i_cfg_data;
            end
            if (i_cmd.load_a) begin
                r_cnt <= r_cnt + NUM_W'(1);
            end
            if (i_cmd.drop) begin
                r_err <= 1'b1;
            end
            if (i_cmd.k_first) begin
                r_k <= NUM_W'(1);
            end else if (i_cmd.k_next) begin
                r_k <= r_k + NUM_W'(1);
            end
            if (i_cmd.edge_lat) begin
                r_i <= '0;
            end else if (i_cmd.i_next) begin
                r_i <= r_i + VTX_W'(1);
            end
            if (i_cmd.edge_wb || i_cmd.mark_wr) begin
                r_row_vld[w_adj_waddr] <= 1'b1;
            end
            if (i_cmd.out_load || i_cmd.empty_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_cnt     <= '0;
                r_err     <= 1'b0;
                r_row_vld <= '0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a) begin
            r_u <= i_in_data.end_a;
            r_v <= i_in_data.end_b;
        end else if (i_cmd.edge_lat) begin
            r_u <= r_ea_q[ELIST_W-1:VTX_W];
            r_v <= r_ea_q[VTX_W-1:0];
        end
        if (i_cmd.edge_lat) begin
            r_acc <= w_adj_rd;
        end else if (i_cmd.cell_val) begin
            r_fv_pend <= w_found_v;
            if (w_found_u && w_found_v) begin
                r_acc <= r_acc | (ROW_W'(1) << w_tum1[EIDX_W-1:0])
                      | (ROW_W'(1) << w_tvm1[EIDX_W-1:0]);
            end else if (w_found_u) begin
                r_acc <= r_acc | (ROW_W'(1) << w_tum1[EIDX_W-1:0]);
            end else if (w_found_v) begin
                r_acc <= r_acc | (ROW_W'(1) << w_tvm1[EIDX_W-1:0]);
            end
        end
        if (i_cmd.out_load) begin
            r_out.row_edge   <= r_k;
            r_out.row_bits   <= w_adj_rd;
            r_out.last_row   <= (r_k == r_cnt);
            r_out.load_error <= r_err;
        end else if (i_cmd.empty_load) begin
            r_out.row_edge   <= '0;
            r_out.row_bits   <= '0;
            r_out.last_row   <= 1'b1;
            r_out.load_error <= r_err;
        end
    end

    // vertex table: cells (a,b) and (b,a) on consecutive cycles of a load
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a) begin
            r_tbl[{i_in_data.end_a, i_in_data.end_b}] <= r_cnt + NUM_W'(1);
        end else if (i_cmd.load_b) begin
            r_tbl[{r_v, r_u}] <= r_cnt;
        end
        if (i_cmd.cell_rd) begin
            r_tu_q <= r_tbl[{r_u, r_i}];
            r_tv_q <= r_tbl[{r_v, r_i}];
        end
    end

    // edge list
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a) begin
            r_elist[r_cnt[EIDX_W-1:0]] <= {i_in_data.end_a, i_in_data.end_b};
        end
        if (i_cmd.edge_rd || i_cmd.cell_chk) begin
            r_ea_q <= r_elist[w_ea_addr];
            r_eb_q <= r_elist[w_tvm1[EIDX_W-1:0]];
        end
    end

    // adjacency rows
    always_ff @(posedge i_clk) begin
        if (i_cmd.edge_wb || i_cmd.mark_wr) begin
            r_adj[w_adj_waddr] <= w_adj_wdata;
        end
        if (i_cmd.edge_rd || i_cmd.mark_rd || i_cmd.out_rd) begin
            r_adj_q     <= r_adj[w_adj_raddr];
            r_adj_vld_q <= r_row_vld[w_adj_raddr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking testbench for line_graph_builder, edge loads and line graph builds
// rows are predicted in place and compared per transfer; depends on lgb_pkg and the rtl only
module tb_top;
    import lgb_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 12;
    localparam int TAIL_CYCLES   = 40;
    localparam int RAND_ITEMS    = 105;

    typedef enum logic [1:0] {ST_LOAD, ST_BUILD, ST_SETN} t_step_kind;

    typedef struct packed {
        t_step_kind       kind;
        logic [NUM_W-1:0] arg_a;
        logic [VTX_W-1:0] arg_b;
        logic             typed;
        t_out_item        row;
    } t_step;

    localparam t_out_item NO_ROW = '0;

    // typed rows only where the answer is obvious
    t_step dir_steps [0:27] = '{
        '{ST_BUILD, 7'd0,   6'd0,  1'b1, '{7'd0, 64'd0, 1'b1, 1'b0}},
        '{ST_LOAD,  7'd63,  6'd63, 1'b0, NO_ROW},
        '{ST_LOAD,  7'd0,   6'd0,  1'b0, NO_ROW},
        '{ST_BUILD, 7'd0,   6'd0,  1'b0, NO_ROW},
        '{ST_LOAD,  7'd0,   6'd1,  1'b0, NO_ROW},
        '{ST_LOAD,  7'd1,   6'd2,  1'b0, NO_ROW},
        '{ST_LOAD,  7'd2,   6'd0,  1'b0, NO_ROW},
        '{ST_LOAD,  7'd1,   6'd0,  1'b0, NO_ROW},
        '{ST_LOAD,  7'd63,  6'd62, 1'b0, NO_ROW},
        '{ST_BUILD, 7'd0,   6'd0,  1'b0, NO_ROW},
        '{ST_SETN,  7'd5,   6'd0,  1'b0, NO_ROW},
        '{ST_LOAD,  7'd5,   6'd0,  1'b0, NO_ROW},
        '{ST_LOAD,  7'd0,   6'd4,  1'b0, NO_ROW},
        '{ST_LOAD,  7'd4,   6'd63, 1'b0, NO_ROW},
        '{ST_BUILD, 7'd0,   6'd0,  1'b1, '{7'd1, 64'd0, 1'b1, 1'b1}},
        '{ST_SETN,  7'd0,   6'd0,  1'b0, NO_ROW},
        '{ST_LOAD,  7'd0,   6'd0,  1'b0, NO_ROW},
        '{ST_BUILD, 7'd0,   6'd0,  1'b1, '{7'd0, 64'd0, 1'b1, 1'b1}},
        '{ST_SETN,  7'd127, 6'd0,  1'b0, NO_ROW},
        '{ST_LOAD,  7'd63,  6'd0,  1'b0, NO_ROW},
        '{ST_LOAD,  7'd0,   6'd5,  1'b0, NO_ROW},
        '{ST_BUILD, 7'd0,   6'd0,  1'b0, NO_ROW},
        '{ST_SETN,  7'd1,   6'd0,  1'b0, NO_ROW},
        '{ST_LOAD,  7'd0,   6'd0,  1'b0, NO_ROW},
        '{ST_LOAD,  7'd0,   6'd0,  1'b0, NO_ROW},
        '{ST_LOAD,  7'd1,   6'd0,  1'b0, NO_ROW},
        '{ST_BUILD, 7'd0,   6'd0,  1'b0, NO_ROW},
        '{ST_SETN,  7'd64,  6'd0,  1'b0, NO_ROW}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_item         i_in_data;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_item        o_out_data;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [NUM_W-1:0] i_cfg_data;

    // predicted state of the builder
    logic [NUM_W-1:0] vcount_reg;
    logic [NUM_W-1:0] cell_edge [0:MAX_VERTICES-1][0:MAX_VERTICES-1];
    logic [VTX_W-1:0] edge_end_a [0:MAX_EDGES-1];
    logic [VTX_W-1:0] edge_end_b [0:MAX_EDGES-1];
    logic [ROW_W-1:0] adj_row [0:MAX_EDGES-1];
    int               edge_cnt;
    logic             drop_seen;

    t_out_item new_rows [$];
    t_out_item rows_due [$];
    t_out_item want_row;
    int        fail_cnt;
    int        items_sent;
    int        cycle_cnt;
    bit        gaps_on;
    bit        hold_req;

    line_graph_builder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void graph_clear();
        for (int x = 0; x < MAX_VERTICES; x++) begin
            for (int y = 0; y < MAX_VERTICES; y++) begin
                cell_edge[x][y] = '0;
            end
        end
        for (int e = 0; e < MAX_EDGES; e++) begin
            edge_end_a[e] = '0;
            edge_end_b[e] = '0;
            adj_row[e]    = '0;
        end
        edge_cnt  = 0;
        drop_seen = 1'b0;
    endfunction

    function automatic void link_edges(input int k, input int j);
        if (k >= 1 && k <= edge_cnt && j >= 1 && j <= edge_cnt) begin
            adj_row[k-1][j-1] = 1'b1;
            adj_row[j-1][k-1] = 1'b1;
        end
    endfunction

    // applies one accepted item and leaves the rows it causes in new_rows
    function automatic void graph_step(input t_in_item it);
        int        n;
        int        k;
        int        i;
        int        u;
        int        v;
        int        cu;
        int        cv;
        t_out_item row;
        new_rows.delete();
        n = (vcount_reg > MAX_VERTICES) ? MAX_VERTICES : int'(vcount_reg);
        if (it.req_type == REQ_LOAD) begin
            if (edge_cnt >= MAX_EDGES || int'(it.end_a) >= n || int'(it.end_b) >= n) begin
                drop_seen = 1'b1;
            end else begin
                edge_cnt++;
                cell_edge[it.end_a][it.end_b] = NUM_W'(edge_cnt);
                cell_edge[it.end_b][it.end_a] = NUM_W'(edge_cnt);
                edge_end_a[edge_cnt-1] = it.end_a;
                edge_end_b[edge_cnt-1] = it.end_b;
            end
        end else begin
            for (k = 1; k <= edge_cnt; k++) begin
                u = int'(edge_end_a[k-1]);
                v = int'(edge_end_b[k-1]);
                for (i = 0; i < n; i++) begin
                    cu = int'(cell_edge[u][i]);
                    cv = int'(cell_edge[v][i]);
                    if (cu != 0 && i != v) link_edges(k, cu);
                    if (cv != 0 && i != u) link_edges(k, cv);
                end
            end
            if (edge_cnt == 0) begin
                row = '{row_edge: '0, row_bits: '0, last_row: 1'b1, load_error: drop_seen};
                new_rows.push_back(row);
            end else begin
                for (k = 1; k <= edge_cnt; k++) begin
                    row.row_edge   = NUM_W'(k);
                    row.row_bits   = adj_row[k-1];
                    row.last_row   = (k == edge_cnt);
                    row.load_error = drop_seen;
                    new_rows.push_back(row);
                end
            end
            graph_clear();
        end
    endfunction

    function automatic t_in_item make_item(input logic req, input int a, input int b);
        t_in_item it;
        it.req_type = req;
        it.end_a    = VTX_W'(a);
        it.end_b    = VTX_W'(b);
        return it;
    endfunction

    task automatic send_item(input t_in_item it, input logic typed, input t_out_item row);
        int r;
        int gap;
        gap = 0;
        if (gaps_on) begin
            r = $urandom_range(0, 99);
            if (r >= 92) gap = $urandom_range(8, 30);
            else if (r >= 60) gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        graph_step(it);
        if (typed) begin
            rows_due.push_back(row);
        end else begin
            foreach (new_rows[q]) rows_due.push_back(new_rows[q]);
        end
    endtask

    task automatic send_load(input int a, input int b);
        send_item(make_item(REQ_LOAD, a, b), 1'b0, NO_ROW);
    endtask

    task automatic send_build();
        send_item(make_item(REQ_BUILD, 0, 0), 1'b0, NO_ROW);
    endtask

    // loads leave no row behind, so give the block time to finish the last one
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (rows_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_vertex_count(input logic [NUM_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        vcount_reg = val;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rows_due.size() == 0) begin
                $display("%0t: unexpected row transfer, expected none, actual %h",
                         $time, o_out_data);
                fail_cnt++;
            end else begin
                want_row = rows_due.pop_front();
                check_field("row_edge", 64'(want_row.row_edge), 64'(o_out_data.row_edge));
                check_field("row_bits", want_row.row_bits, o_out_data.row_bits);
                check_field("last_row", 64'(want_row.last_row), 64'(o_out_data.last_row));
                check_field("load_error", 64'(want_row.load_error),
                            64'(o_out_data.load_error));
            end
        end
    end

    // receiver side, with one long hold once a held build starts to drain
    initial begin
        int r;
        int n;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req && o_out_valid) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    i_out_stall <= 1'b0;
                    n = $urandom_range(1, 16);
                end else if (r < 90) begin
                    i_out_stall <= 1'b1;
                    n = $urandom_range(1, 3);
                end else begin
                    i_out_stall <= 1'b1;
                    n = $urandom_range(10, 40);
                end
                repeat (n) @(posedge i_clk);
            end
        end
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("[line_graph_builder] ERROR");
        $finish;
    end

    initial begin
        t_step step;
        int    r;
        int    nv;
        int    eff;
        int    nloads;
        int    a;
        int    b;
        int    j;
        int    tmp;
        int    rand_goal;
        int    star [0:MAX_EDGES-1];
        fail_cnt    = 0;
        items_sent  = 0;
        hold_req    = 1'b0;
        gaps_on     = 1'b1;
        vcount_reg  = 7'd64;
        graph_clear();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int s = 0; s < 28; s++) begin
            step = dir_steps[s];
            if (step.kind == ST_SETN) begin
                wait_drained();
                write_vertex_count(step.arg_a);
            end else begin
                send_item(make_item(step.kind == ST_BUILD ? REQ_BUILD : REQ_LOAD,
                                    int'(step.arg_a[VTX_W-1:0]), int'(step.arg_b)),
                          step.typed, step.row);
            end
        end
        wait_drained();

        // full store: a star around vertex 0 in random order, every row nearly all ones
        for (int e = 0; e < MAX_EDGES; e++) star[e] = e;
        for (int e = MAX_EDGES - 1; e > 0; e--) begin
            j       = $urandom_range(0, e);
            tmp     = star[e];
            star[e] = star[j];
            star[j] = tmp;
        end
        for (int e = 0; e < MAX_EDGES; e++) send_load(0, star[e]);
        send_load($urandom_range(0, 63), $urandom_range(0, 63));
        send_load(63, 63);
        hold_req = 1'b1;
        send_build();
        // offered while the rows above are held back
        for (int e = 0; e < 8; e++) send_load($urandom_range(0, 63), $urandom_range(0, 63));
        send_build();
        wait_drained();

        rand_goal = items_sent + RAND_ITEMS;
        while (items_sent < rand_goal) begin
            r = $urandom_range(0, 9);
            case (r)
                0, 1, 2, 3: nv = $urandom_range(1, 64);
                4:          nv = 64;
                5:          nv = 1;
                6:          nv = $urandom_range(65, 127);
                7:          nv = 0;
                default:    nv = $urandom_range(2, 8);
            endcase
            eff = (nv > MAX_VERTICES) ? MAX_VERTICES : nv;
            write_vertex_count(NUM_W'(nv));
            gaps_on = ($urandom_range(0, 3) != 0);
            nloads  = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 30)
                                                  : $urandom_range(0, 12);
            for (int e = 0; e < nloads; e++) begin
                r = $urandom_range(0, 19);
                if (eff == 0 || r >= 17) begin
                    a = $urandom_range(0, 63);
                    b = $urandom_range(0, 63);
                end else if (r == 16) begin
                    a = $urandom_range(0, eff - 1);
                    b = a;
                end else begin
                    a = $urandom_range(0, eff - 1);
                    b = $urandom_range(0, eff - 1);
                end
                send_load(a, b);
                if ($urandom_range(0, 14) == 0) begin
                    send_build();
                    if ($urandom_range(0, 1) == 0) wait_drained();
                end
            end
            send_build();
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("[line_graph_builder] OK");
        end else begin
            $display("[line_graph_builder] ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/lgb_pkg.sv
src/lgb_ctrl.sv
src/lgb_dpath.sv
src/line_graph_builder.sv
tb/tb_top.sv
